// ----- rtl/wpg_pkg.sv -----
// shared types, constants and helper functions of the word packing gap encoder
// no dependencies; used by every module of the block but wpg_ram
package wpg_pkg;

	localparam int PAYLOAD_BITS        = 28;
	localparam int SCAN_LIMIT          = PAYLOAD_BITS + 1;
	localparam int LOOKAHEAD_DEPTH_DEF = 32;
	localparam int DOC_BITS            = 32;
	localparam int LEN_BITS            = 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_PACK_START,
		ST_PACK,
		ST_EMIT,
		ST_ERR
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan_start;
		logic scan_step;
		logic pack_start;
		logic pack_step;
		logic emit;
		logic err_emit;
		logic item_done;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic gap_wide;
		logic count_zero;
		logic scan_hit;
		logic scan_exhausted;
		logic pack_last;
		logic out_free;
		logic end_flag;
	} sts_t;

	// number of significant bits of a gap
	function automatic logic [LEN_BITS-1:0] bit_len(input logic [PAYLOAD_BITS-1:0] v);
		logic [LEN_BITS-1:0] n;
		n = '0;
		for (int i = 0; i < PAYLOAD_BITS; i++) begin
			if (v[i]) n = LEN_BITS'(i + 1);
		end
		return n;
	endfunction

	// round a bit length up to a supported slot width
	function automatic logic [LEN_BITS-1:0] round_width(input logic [LEN_BITS-1:0] b);
		logic [LEN_BITS-1:0] w;
		if (b > 5'd14)      w = 5'd28;
		else if (b > 5'd9)  w = 5'd14;
		else if (b > 5'd7)  w = 5'd9;
		else if (b > 5'd5)  w = 5'd7;
		else if (b == 5'd0) w = 5'd1;
		else                w = b;
		return w;
	endfunction

	// gaps held by one word of a given width
	function automatic logic [LEN_BITS-1:0] slots(input logic [LEN_BITS-1:0] w);
		logic [LEN_BITS-1:0] n;
		case (w)
			5'd1:    n = 5'd28;
			5'd2:    n = 5'd14;
			5'd3:    n = 5'd9;
			5'd4:    n = 5'd7;
			5'd5:    n = 5'd5;
			5'd7:    n = 5'd4;
			5'd9:    n = 5'd3;
			5'd14:   n = 5'd2;
			default: n = 5'd1;
		endcase
		return n;
	endfunction

endpackage

// ----- rtl/word_packing_gap_encoder.sv -----
// top level of the word packing gap encoder
// depends on wpg_pkg, wpg_ctrl, wpg_datapath (and wpg_ram below it)
//
// channel  | direction | tdata                     | tlast      | tuser
// s_axis   | in        | doc_number [31:0]         | list_end   | -
// m_axis   | out       | packed_word [31:0]        | last_word  | gap_too_wide
//
// one item at a time; an item is accepted in idle and checked in start, then each word is
// scanned, packed and emitted (prefix scan and packing read one buffer entry a cycle)
// an item whose last scan stays incomplete returns to idle; a wide gap emits an error word
// reset clears the list state and the output valid flag; no clearing pass
// a stalled result waits in the output register; the next word waits for it

module word_packing_gap_encoder #(
	parameter int LOOKAHEAD_DEPTH = wpg_pkg::LOOKAHEAD_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // doc_number [31:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // packed_word [31:0]
	output logic        m_axis_tlast,
	output logic        m_axis_tuser    // gap_too_wide [0]
);

	wpg_pkg::cmd_t cmd;
	wpg_pkg::sts_t sts;

	// sequencer
	wpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	wpg_datapath #(
		.LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_doc    (s_axis_tdata),
		.in_end    (s_axis_tlast),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_word  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_err   (m_axis_tuser)
	);

endmodule

// ----- rtl/wpg_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
module wpg_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/wpg_datapath.sv -----
// datapath: gap forming, lookahead buffer, prefix scan, word packing, output register
// depends on wpg_pkg and wpg_ram
module wpg_datapath #(
	parameter int LOOKAHEAD_DEPTH = wpg_pkg::LOOKAHEAD_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wpg_pkg::cmd_t                 cmd,
	input  logic [wpg_pkg::DOC_BITS-1:0]  in_doc,
	input  logic                          in_end,
	input  logic                          out_ready,
	output wpg_pkg::sts_t                 sts,
	output logic                          out_valid,
	output logic [31:0]                   out_word,
	output logic                          out_last,
	output logic                          out_err
);

	localparam int AW = $clog2(LOOKAHEAD_DEPTH);
	localparam int CW = $clog2(LOOKAHEAD_DEPTH + 1);
	localparam int PB = wpg_pkg::PAYLOAD_BITS;
	localparam int LB = wpg_pkg::LEN_BITS;

	logic [wpg_pkg::DOC_BITS-1:0] prev_q;
	logic                         wide_q;
	logic                         end_q;
	logic [AW-1:0]                head_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                ri_q;
	logic [CW-1:0]                ci_q;
	logic [LB-1:0]                maxb_q;
	logic [LB-1:0]                width_q;
	logic [PB-1:0]                acc_q;
	logic [LB-1:0]                pos_q;
	logic                         out_valid_q;
	logic [31:0]                  out_word_q;
	logic                         out_last_q;
	logic                         out_err_q;

	logic [wpg_pkg::DOC_BITS-1:0] gap_in;
	logic                         wide_in;
	logic                         buf_full;
	logic [PB-1:0]                rdata;
	logic [AW-1:0]                raddr;
	logic [AW-1:0]                waddr;
	logic                         we;
	logic [LB-1:0]                blen;
	logic [LB-1:0]                mlen;
	logic [CW-1:0]                e1;
	logic [LB+CW-1:0]             prod;
	logic [LB-1:0]                nslots;
	logic [CW-1:0]                take;
	logic [CW-1:0]                count_left;
	logic [PB-1:0]                mask;
	logic [PB-1:0]                gm;
	logic                         out_free;

	// circular buffer index: base plus offset, wrapped once
	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(off);
		if (s >= (CW+1)'(LOOKAHEAD_DEPTH)) s = s - (CW+1)'(LOOKAHEAD_DEPTH);
		return s[AW-1:0];
	endfunction

	// gap of the incoming document number
	assign gap_in  = in_doc - prev_q;
	assign wide_in = |gap_in[wpg_pkg::DOC_BITS-1:PB];

	// buffer storage; a gap arriving at a full buffer is dropped
	assign buf_full = (count_q == CW'(LOOKAHEAD_DEPTH));
	assign we    = cmd.accept && !wide_in && !buf_full;
	assign waddr = wrap(head_q, count_q);
	assign raddr = (cmd.scan_start || cmd.pack_start) ? head_q : wrap(head_q, ri_q);

	wpg_ram #(
		.WIDTH (PB),
		.DEPTH (LOOKAHEAD_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (gap_in[PB-1:0]),
		.raddr (raddr),
		.rdata (rdata)
	);

	// prefix scan step
	assign blen = wpg_pkg::bit_len(rdata);
	assign mlen = (blen > maxb_q) ? blen : maxb_q;
	assign e1   = ci_q + CW'(1);
	assign prod = (LB+CW)'(mlen) * (LB+CW)'(e1);

	// packing step
	assign nslots     = wpg_pkg::slots(width_q);
	assign take       = (CW'(nslots) < count_q) ? CW'(nslots) : count_q;
	assign count_left = count_q - take;
	assign mask       = {PB{1'b1}} >> (LB'(PB) - width_q);
	assign gm         = (ci_q < count_q) ? (rdata & mask) : '0;
	assign out_free   = !out_valid_q || out_ready;

	// status to the controller
	always_comb begin
		sts.gap_wide       = wide_q;
		sts.count_zero     = (count_q == '0);
		sts.scan_hit       = (prod >= (LB+CW)'(wpg_pkg::SCAN_LIMIT));
		sts.scan_exhausted = (e1 == count_q);
		sts.pack_last      = (ci_q == CW'(nslots - LB'(1)));
		sts.out_free       = out_free;
		sts.end_flag       = end_q;
	end

	// list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			head_q  <= '0;
			count_q <= '0;
			wide_q  <= 1'b0;
			end_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				wide_q <= wide_in;
				end_q  <= in_end;
				if (!wide_in) begin
					if (!buf_full) count_q <= count_q + CW'(1);
					prev_q  <= in_doc;
				end
			end
			if (cmd.emit) begin
				head_q  <= wrap(head_q, take);
				count_q <= count_left;
			end
			if (cmd.err_emit) begin
				head_q  <= '0;
				count_q <= '0;
				prev_q  <= '0;
			end
			if (cmd.item_done && end_q) prev_q <= '0;
		end
	end

	// scan and pack working registers
	always_ff @(posedge clk) begin
		if (cmd.scan_start || cmd.pack_start) begin
			ri_q   <= CW'(1);
			ci_q   <= '0;
			maxb_q <= '0;
			acc_q  <= '0;
			pos_q  <= '0;
		end
		if (cmd.scan_step) begin
			maxb_q  <= mlen;
			width_q <= wpg_pkg::round_width(mlen);
			ri_q    <= ri_q + CW'(1);
			ci_q    <= e1;
		end
		if (cmd.pack_step) begin
			acc_q <= acc_q | (gm << pos_q);
			pos_q <= pos_q + width_q;
			ri_q  <= ri_q + CW'(1);
			ci_q  <= e1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.err_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_word_q <= {acc_q, width_q[3:0]};
			out_last_q <= end_q && (count_left == '0);
			out_err_q  <= 1'b0;
		end else if (cmd.err_emit) begin
			out_word_q <= '0;
			out_last_q <= 1'b0;
			out_err_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_last  = out_last_q;
	assign out_err   = out_err_q;

endmodule

// ----- rtl/wpg_ctrl.sv -----
// controller state machine: sequences accept, scan, pack and emit per word, and the error word
// depends on wpg_pkg
module wpg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  wpg_pkg::sts_t    sts,
	output wpg_pkg::cmd_t    cmd
);

	wpg_pkg::state_t state_q;
	wpg_pkg::state_t state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wpg_pkg::ST_IDLE: begin
				if (in_valid) state_d = wpg_pkg::ST_START;
			end
			wpg_pkg::ST_START: begin
				if (sts.gap_wide)        state_d = wpg_pkg::ST_ERR;
				else if (sts.count_zero) state_d = wpg_pkg::ST_IDLE;
				else                     state_d = wpg_pkg::ST_SCAN;
			end
			wpg_pkg::ST_SCAN: begin
				if (sts.scan_hit || (sts.scan_exhausted && sts.end_flag))
					state_d = wpg_pkg::ST_PACK_START;
				else if (sts.scan_exhausted)
					state_d = wpg_pkg::ST_IDLE;
			end
			wpg_pkg::ST_PACK_START: state_d = wpg_pkg::ST_PACK;
			wpg_pkg::ST_PACK: begin
				if (sts.pack_last) state_d = wpg_pkg::ST_EMIT;
			end
			wpg_pkg::ST_EMIT: begin
				if (sts.out_free) state_d = wpg_pkg::ST_START;
			end
			wpg_pkg::ST_ERR: begin
				if (sts.out_free) state_d = wpg_pkg::ST_IDLE;
			end
			default: state_d = wpg_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			wpg_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			wpg_pkg::ST_START: begin
				cmd.scan_start = !sts.gap_wide && !sts.count_zero;
				cmd.item_done  = !sts.gap_wide && sts.count_zero;
			end
			wpg_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.item_done = sts.scan_exhausted && !sts.scan_hit && !sts.end_flag;
			end
			wpg_pkg::ST_PACK_START: cmd.pack_start = 1'b1;
			wpg_pkg::ST_PACK:       cmd.pack_step  = 1'b1;
			wpg_pkg::ST_EMIT:       cmd.emit       = sts.out_free;
			wpg_pkg::ST_ERR:        cmd.err_emit   = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= wpg_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

endmodule
